FILE: sv/accel_tilt_angles_macros.svh
// ----------------------------------------------------------------------------
// accel_tilt_angles assertion macros
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_MACROS_SVH
`define ACCEL_TILT_ANGLES_MACROS_SVH

// same-cycle implication
`define ATA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tilt check failed");

// implication after a fixed number of cycles
`define ATA_ASSERT_LAT(lbl, ante, cons, n) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) \
		else $error("tilt latency check failed");

`endif

FILE: sv/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg
// Widths, constants, arctangent table and shared types for the tilt block.
// ----------------------------------------------------------------------------
package ata_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int CORDIC_STEPS = 16;

	localparam int TABLE_LEN = 24;
	localparam int VEC_FRAC  = 24;
	localparam int HYP_FRAC  = 32 - SAMPLE_BITS;

	localparam int MAG_W     = SAMPLE_BITS;
	localparam int SQ_W      = 2 * SAMPLE_BITS;
	localparam int RAD_W     = SQ_W + 2 * HYP_FRAC;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int SQ_DIGS   = 2;
	localparam int SQ_STAGES = ROOT_W / SQ_DIGS;

	localparam int VEC_W     = SAMPLE_BITS + VEC_FRAC + 3;
	localparam int ANG_W     = 33;
	localparam int ANG_FRAC  = 30;

	// degrees = floor(a * 9000 / (157 * 2^30))
	localparam int DEG_NUM    = 9000;
	localparam int DEG_NUM_W  = 14;
	localparam int DEG_DEN    = 157;
	localparam int DEG_DEN_W  = 8;
	localparam int DEG_RCP    = 417;
	localparam int DEG_RCP_W  = 9;
	localparam int DEG_RCP_SH = 16;
	localparam int DEG_MAX    = 90;
	localparam int TILT_W     = 8;

	// start accepted to result strobe sampled
	localparam int LATENCY = 8 + SQ_STAGES + CORDIC_STEPS;

	typedef struct packed {
		logic valid;
		logic zero;
		logic neg;
	} ata_tag_t;

	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic [MAG_W-1:0] az;
		logic             z_zero;
		logic             yz_zero;
		logic             neg_x;
		logic             neg_t;
	} ata_side_t;

	// atan(2^-i) in radians, Q30, truncated
	function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
		logic [31:0] r;
		unique case (i)
			0:  r = 32'h3243F6A8;
			1:  r = 32'h1DAC6705;
			2:  r = 32'h0FADBAFC;
			3:  r = 32'h07F56EA6;
			4:  r = 32'h03FEAB76;
			5:  r = 32'h01FFD55B;
			6:  r = 32'h00FFFAAA;
			7:  r = 32'h007FFF55;
			8:  r = 32'h003FFFEA;
			9:  r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			default: r = 32'h0;
		endcase
		return $signed(ANG_W'(r));
	endfunction

endpackage

FILE: sv/ata_isqrt.sv
// ----------------------------------------------------------------------------
// ata_isqrt
// Pipelined restoring integer square root, two root bits per stage.
// ----------------------------------------------------------------------------
module ata_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [ata_pkg::RAD_W-1:0]  rad,
	output logic                       out_valid,
	output logic [ata_pkg::ROOT_W-1:0] root
);
	import ata_pkg::*;

	localparam int REM_W = ROOT_W + 3;

	logic              v_s    [SQ_STAGES];
	logic [RAD_W-1:0]  rad_s  [SQ_STAGES];
	logic [REM_W-1:0]  rem_s  [SQ_STAGES];
	logic [ROOT_W-1:0] root_s [SQ_STAGES];

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		logic              v_i;
		logic [RAD_W-1:0]  rad_i;
		logic [REM_W-1:0]  rem_i;
		logic [ROOT_W-1:0] root_i;
		logic [RAD_W-1:0]  rad_o;
		logic [REM_W-1:0]  rem_o;
		logic [ROOT_W-1:0] root_o;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_next
			assign v_i    = v_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
		end

		always_comb begin
			logic [REM_W-1:0] trial;
			rad_o  = rad_i;
			rem_o  = rem_i;
			root_o = root_i;
			for (int d = 0; d < SQ_DIGS; d++) begin
				rem_o = {rem_o[REM_W-3:0], rad_o[RAD_W-1 -: 2]};
				rad_o = rad_o << 2;
				trial = REM_W'({root_o, 2'b01});
				if (rem_o >= trial) begin
					rem_o  = rem_o - trial;
					root_o = {root_o[ROOT_W-2:0], 1'b1};
				end else begin
					root_o = {root_o[ROOT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k]  <= rad_o;
			rem_s[k]  <= rem_o;
			root_s[k] <= root_o;
		end
	end

	assign out_valid = v_s[SQ_STAGES-1];
	assign root      = root_s[SQ_STAGES-1];

endmodule

FILE: sv/ata_cordic.sv
// ----------------------------------------------------------------------------
// ata_cordic
// Vectoring CORDIC, one step per stage, then conversion to signed degrees.
// ----------------------------------------------------------------------------
module ata_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ata_pkg::ata_tag_t                   tag_in,
	input  logic signed [ata_pkg::VEC_W-1:0]    px,
	input  logic signed [ata_pkg::VEC_W-1:0]    py,
	output logic                                out_valid,
	output logic signed [ata_pkg::TILT_W-1:0]   deg
);
	import ata_pkg::*;

	localparam int PROD_W = ANG_W - 1 + DEG_NUM_W;
	localparam int M_W    = PROD_W - ANG_FRAC;
	localparam int P_W    = M_W + DEG_RCP_W;
	localparam int Q_W    = P_W - DEG_RCP_SH;
	localparam int T_W    = Q_W + DEG_DEN_W;

	logic signed [VEC_W-1:0] x_s   [CORDIC_STEPS];
	logic signed [VEC_W-1:0] y_s   [CORDIC_STEPS];
	logic signed [ANG_W-1:0] a_s   [CORDIC_STEPS];
	ata_tag_t                tag_s [CORDIC_STEPS];

	for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_step
		logic signed [VEC_W-1:0] x_i;
		logic signed [VEC_W-1:0] y_i;
		logic signed [ANG_W-1:0] a_i;
		ata_tag_t                tag_i;
		logic signed [VEC_W-1:0] dx;
		logic signed [VEC_W-1:0] dy;

		if (j == 0) begin : g_first
			assign x_i   = px;
			assign y_i   = py;
			assign a_i   = '0;
			assign tag_i = tag_in;
		end else begin : g_next
			assign x_i   = x_s[j-1];
			assign y_i   = y_s[j-1];
			assign a_i   = a_s[j-1];
			assign tag_i = tag_s[j-1];
		end

		assign dx = y_i >>> j;
		assign dy = x_i >>> j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[j] <= '0;
			end else begin
				tag_s[j] <= tag_i;
			end
		end

		always_ff @(posedge clk) begin
			if (!y_i[VEC_W-1]) begin
				x_s[j] <= x_i + dx;
				y_s[j] <= y_i - dy;
				a_s[j] <= a_i + atan_q30(j);
			end else begin
				x_s[j] <= x_i - dx;
				y_s[j] <= y_i + dy;
				a_s[j] <= a_i - atan_q30(j);
			end
		end
	end

	logic signed [ANG_W-1:0] a_last;
	logic [ANG_W-2:0]        a_cl;
	ata_tag_t                tag_s1, tag_s2, tag_s3, tag_s4;
	logic [PROD_W-1:0]       prod_s1;
	logic [M_W-1:0]          m_s2, m_s3;
	logic [P_W-1:0]          p_s2;
	logic [Q_W-1:0]          q0_s3;
	logic [T_W-1:0]          t_s3;
	logic [T_W-1:0]          rem;
	logic [Q_W-1:0]          q;
	logic [TILT_W-1:0]       mag;
	logic signed [TILT_W-1:0] deg_s4;

	assign a_last = a_s[CORDIC_STEPS-1];
	assign a_cl   = a_last[ANG_W-1] ? '0 : a_last[ANG_W-2:0];

	// quotient estimate is low by at most one
	assign rem = T_W'(m_s3) - t_s3;
	assign q   = (rem >= T_W'(DEG_DEN)) ? q0_s3 + Q_W'(1) : q0_s3;
	assign mag = (q > Q_W'(DEG_MAX)) ? TILT_W'(DEG_MAX) : q[TILT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag_s[CORDIC_STEPS-1];
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a_cl) * PROD_W'(DEG_NUM);
		m_s2    <= prod_s1[PROD_W-1:ANG_FRAC];
		p_s2    <= P_W'(prod_s1[PROD_W-1:ANG_FRAC]) * P_W'(DEG_RCP);
		m_s3    <= m_s2;
		q0_s3   <= p_s2[P_W-1:DEG_RCP_SH];
		t_s3    <= T_W'(p_s2[P_W-1:DEG_RCP_SH]) * T_W'(DEG_DEN);
		if (tag_s3.zero) begin
			deg_s4 <= '0;
		end else if (tag_s3.neg) begin
			deg_s4 <= $signed(-mag);
		end else begin
			deg_s4 <= $signed(mag);
		end
	end

	assign out_valid = tag_s4.valid;
	assign deg       = deg_s4;

endmodule

FILE: sv/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Pitch and roll in whole degrees from one three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// Fully pipelined: one sample is taken on every cycle that start is high, and
// busy never rises. Each result appears on done for one cycle, once its sample
// has passed the input registers, 16 square root stages, 16 CORDIC steps and
// the degree conversion registers. The square root resolves two root bits per
// stage, and the CORDIC one iteration per stage. The receiver cannot hold
// results off, so it must take every done strobe.
module accel_tilt_angles (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [ata_pkg::SAMPLE_BITS-1:0] accel_x,
	input  logic signed [ata_pkg::SAMPLE_BITS-1:0] accel_y,
	input  logic signed [ata_pkg::SAMPLE_BITS-1:0] accel_z,
	output logic                                  done,
	output logic signed [ata_pkg::TILT_W-1:0]      tilt_about_x,
	output logic signed [ata_pkg::TILT_W-1:0]      tilt_about_y
);
	import ata_pkg::*;

	localparam int SB = SAMPLE_BITS;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [SB-1:0] x_s1, y_s1, z_s1;
	ata_side_t            side_s2, side_s3, side_s4;
	logic [SQ_W-1:0]      ysq_s3, zsq_s3;
	logic [SQ_W-1:0]      sq_s4;
	ata_side_t            side_d [SQ_STAGES];

	logic                 root_valid;
	logic [ROOT_W-1:0]    root;
	ata_tag_t             tag_x, tag_y;
	logic signed [VEC_W-1:0] px_x, py_x, px_y, py_y;
	logic                 done_x, done_y;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= accel_x;
		y_s1 <= accel_y;
		z_s1 <= accel_z;

		side_s2.ax      <= x_s1[SB-1] ? MAG_W'(-x_s1) : MAG_W'(x_s1);
		side_s2.ay      <= y_s1[SB-1] ? MAG_W'(-y_s1) : MAG_W'(y_s1);
		side_s2.az      <= z_s1[SB-1] ? MAG_W'(-z_s1) : MAG_W'(z_s1);
		side_s2.z_zero  <= (z_s1 == '0);
		side_s2.yz_zero <= (y_s1 == '0) && (z_s1 == '0);
		side_s2.neg_x   <= x_s1[SB-1];
		side_s2.neg_t   <= (y_s1 != '0) && (y_s1[SB-1] != z_s1[SB-1]);

		side_s3 <= side_s2;
		ysq_s3  <= SQ_W'(side_s2.ay) * SQ_W'(side_s2.ay);
		zsq_s3  <= SQ_W'(side_s2.az) * SQ_W'(side_s2.az);

		side_s4 <= side_s3;
		sq_s4   <= ysq_s3 + zsq_s3;
	end

	// side data delayed to line up with the root
	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				side_d[k] <= side_s4;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	ata_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.rad       (RAD_W'(sq_s4) << (2 * HYP_FRAC)),
		.out_valid (root_valid),
		.root      (root)
	);

	assign px_x = $signed(VEC_W'(side_d[SQ_STAGES-1].az) << VEC_FRAC);
	assign py_x = $signed(VEC_W'(side_d[SQ_STAGES-1].ay) << VEC_FRAC);
	assign px_y = $signed(VEC_W'(root) << (VEC_FRAC - HYP_FRAC));
	assign py_y = $signed(VEC_W'(side_d[SQ_STAGES-1].ax) << VEC_FRAC);

	assign tag_x = '{valid: root_valid, zero: side_d[SQ_STAGES-1].z_zero,
		neg: side_d[SQ_STAGES-1].neg_t};
	assign tag_y = '{valid: root_valid, zero: side_d[SQ_STAGES-1].yz_zero,
		neg: side_d[SQ_STAGES-1].neg_x};

	ata_cordic u_cordic_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tag_x),
		.px        (px_x),
		.py        (py_x),
		.out_valid (done_x),
		.deg       (tilt_about_x)
	);

	ata_cordic u_cordic_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tag_y),
		.px        (px_y),
		.py        (py_y),
		.out_valid (done_y),
		.deg       (tilt_about_y)
	);

	assign done = done_x && done_y;

endmodule

FILE: sv/ata_checker.sv
// ----------------------------------------------------------------------------
// ata_checker
// Port-level checks on latency, range, zero and sign of the tilt results.
// ----------------------------------------------------------------------------
`include "accel_tilt_angles_macros.svh"

module ata_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic signed [ata_pkg::SAMPLE_BITS-1:0] accel_x,
	input logic signed [ata_pkg::SAMPLE_BITS-1:0] accel_y,
	input logic signed [ata_pkg::SAMPLE_BITS-1:0] accel_z,
	input logic                                  done,
	input logic signed [ata_pkg::TILT_W-1:0]      tilt_about_x,
	input logic signed [ata_pkg::TILT_W-1:0]      tilt_about_y
);
	import ata_pkg::*;

	`ATA_ASSERT_NOW(a_range, done, (tilt_about_x <= 8'sd90) && (tilt_about_x >= -8'sd90) && (tilt_about_y <= 8'sd90) && (tilt_about_y >= -8'sd90))
	`ATA_ASSERT_LAT(a_latency, start && !busy, done, LATENCY)
	`ATA_ASSERT_LAT(a_z_zero, start && !busy && (accel_z == '0), tilt_about_x == '0, LATENCY)
	`ATA_ASSERT_LAT(a_y_sign, start && !busy && !accel_x[SAMPLE_BITS-1], !tilt_about_y[TILT_W-1], LATENCY)

endmodule

bind accel_tilt_angles ata_checker u_ata_checker (.*);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for accel_tilt_angles. Samples go in through the start/busy
// handshake. A tilt predictor computes the expected pitch and roll of every
// accepted sample, and each done strobe is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ata_pkg::*;

	typedef struct {
		logic signed [TILT_W-1:0] about_x;
		logic signed [TILT_W-1:0] about_y;
	} tilt_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic signed [SAMPLE_BITS-1:0] accel_x = '0;
	logic signed [SAMPLE_BITS-1:0] accel_y = '0;
	logic signed [SAMPLE_BITS-1:0] accel_z = '0;
	logic                          done;
	logic signed [TILT_W-1:0]      tilt_about_x;
	logic signed [TILT_W-1:0]      tilt_about_y;

	tilt_t pending_tilts[$];
	int    mismatches = 0;
	int    samples_taken = 0;
	int    tilts_checked = 0;
	logic  took = 1'b0;

	// atan(2^-i), radians Q30, truncated
	longint atan_tab[TABLE_LEN] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	accel_tilt_angles dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.done(done), .tilt_about_x(tilt_about_x), .tilt_about_y(tilt_about_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// arithmetic shift rounds toward minus infinity
	function automatic longint vec_degrees(input longint px, input longint py);
		longint acc;
		longint dx;
		longint dy;
		longint deg;
		acc = 0;
		for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
			dx = py >>> i;
			dy = px >>> i;
			if (py >= 0) begin
				px += dx;
				py -= dy;
				acc += atan_tab[i];
			end else begin
				px -= dx;
				py += dy;
				acc -= atan_tab[i];
			end
		end
		if (acc < 0)
			acc = 0;
		deg = (acc * DEG_NUM) / (longint'(DEG_DEN) << ANG_FRAC);
		if (deg > DEG_MAX)
			deg = DEG_MAX;
		return deg;
	endfunction

	function automatic tilt_t predict_tilt(input logic signed [SAMPLE_BITS-1:0] sx,
			input logic signed [SAMPLE_BITS-1:0] sy, input logic signed [SAMPLE_BITS-1:0] sz);
		tilt_t t;
		longint x, y, z, ax, ay, az, d;
		longint unsigned h;
		x = longint'(sx);
		y = longint'(sy);
		z = longint'(sz);
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		az = z < 0 ? -z : z;
		t.about_x = '0;
		t.about_y = '0;
		if (z != 0) begin
			d = vec_degrees(az << VEC_FRAC, ay << VEC_FRAC);
			t.about_x = ((y != 0) && ((y < 0) != (z < 0))) ? TILT_W'(-d) : TILT_W'(d);
		end
		if (y != 0 || z != 0) begin
			h = int_sqrt(longint'(ay * ay + az * az) << (2 * HYP_FRAC));
			d = vec_degrees(longint'(h << (VEC_FRAC - HYP_FRAC)), ax << VEC_FRAC);
			t.about_y = (x < 0) ? TILT_W'(-d) : TILT_W'(d);
		end
		return t;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// accepted samples become expectations
	always @(posedge clk) begin
		took <= start && !busy && arst_n;
		if (arst_n && start && !busy) begin
			pending_tilts.push_back(predict_tilt(accel_x, accel_y, accel_z));
			samples_taken++;
		end
	end

	always @(posedge clk) begin
		tilt_t want;
		if (arst_n && done) begin
			if (pending_tilts.size() == 0) begin
				report("unexpected result", tilt_about_x, 0);
			end else begin
				want = pending_tilts.pop_front();
				if (tilt_about_x !== want.about_x)
					report("tilt_about_x", tilt_about_x, want.about_x);
				if (tilt_about_y !== want.about_y)
					report("tilt_about_y", tilt_about_y, want.about_y);
				tilts_checked++;
			end
		end
	end

	int gap_mode = 0;

	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x,
			input logic signed [SAMPLE_BITS-1:0] y, input logic signed [SAMPLE_BITS-1:0] z);
		int gap;
		gap = 0;
		if (gap_mode != 0) begin
			if ($urandom_range(0, 9) >= 7)
				gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 45);
		end
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		accel_x = x;
		accel_y = y;
		accel_z = z;
		start = 1'b1;
		do @(negedge clk); while (!took);
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending_tilts.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		send_sample(0, 0, 0);
		send_sample(-32768, -32768, -32768);
		send_sample(32767, 32767, 32767);
		send_sample(32767, 0, 0);
		send_sample(-32768, 0, 0);
		send_sample(0, 32767, 0);
		send_sample(0, -32768, 0);
		send_sample(0, 0, 16384);
		send_sample(0, 0, -16384);
		send_sample(1, 1, 1);
		send_sample(-1, -1, 1);
		send_sample(1, 1, -1);
		send_sample(-1, 1, -1);
		send_sample(32767, 1, 1);
		send_sample(-32768, -1, 1);
		send_sample(1, 32767, 1);
		send_sample(1, -32768, -1);
		send_sample(100, 0, 32767);
		send_sample(-100, 5, -32768);
		send_sample(16384, 16384, 16384);
		send_sample(-12000, 7000, -9000);
		drain();
	endtask

	task automatic test_random_full(input int n);
		gap_mode = 1;
		repeat (n)
			send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
				SAMPLE_BITS'($urandom));
	endtask

	task automatic test_random_small(input int n);
		repeat (n)
			send_sample(SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32),
				SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32),
				SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32));
	endtask

	task automatic test_random_zero_axes(input int n);
		logic signed [SAMPLE_BITS-1:0] v[3];
		repeat (n) begin
			foreach (v[i])
				v[i] = ($urandom_range(0, 2) == 0) ? '0 : SAMPLE_BITS'($urandom);
			send_sample(v[0], v[1], v[2]);
		end
	endtask

	task automatic test_back_to_back(input int n);
		gap_mode = 0;
		repeat (n)
			send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
				SAMPLE_BITS'($urandom));
		gap_mode = 1;
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_full(700);
		drain();
		test_random_small(250);
		test_random_zero_axes(250);
		test_back_to_back(230);
		drain();
		repeat (LATENCY + 10) @(negedge clk);
		$display("Covered %0d samples (directed extremes, zero axes, small and full range),",
			samples_taken);
		$display("%0d tilt results checked, %0d mismatches.", tilts_checked, mismatches);
		if (mismatches == 0 && pending_tilts.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout waiting for tilt results");
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/ata_pkg.sv
sv/ata_isqrt.sv
sv/ata_cordic.sv
sv/accel_tilt_angles.sv
sv/ata_checker.sv
dv/tb.sv
